>>> rtl/mmst_pkg.sv
// Package for the matrix multiply block with sparse triplet output.
// Holds field widths, request and register codes, sequencer states and the MAC control word.
// No dependencies.
package mmst_pkg;

  localparam int VAL_W     = 34;
  localparam int REQ_W     = 2;
  localparam int POS_W     = 2;
  localparam int OUT_POS_W = 3;
  localparam int CFG_W     = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] DIM_RESET = 3'd4;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD_A  = 2'd0,
    REQ_LOAD_B  = 2'd1,
    REQ_COMPUTE = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_COLS_B    = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_MUL,
    ST_ACC,
    ST_WR,
    ST_HDR,
    ST_SCAN,
    ST_CHK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic mul;
    logic acc;
  } mac_ctrl_t;

endpackage

>>> rtl/mmst_if.sv
// Handshake channels of the matrix multiply block: request words in, triplet words out.
// Depends on mmst_pkg.
interface mmst_in_if #(parameter int ELEM_WIDTH = 16) ();
  import mmst_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [REQ_W-1:0]             req_type;
  logic [POS_W-1:0]             elem_row;
  logic [POS_W-1:0]             elem_col;
  logic signed [ELEM_WIDTH-1:0] elem_value;

  modport source(output valid, req_type, elem_row, elem_col, elem_value, input ready);
  modport sink(input valid, req_type, elem_row, elem_col, elem_value, output ready);
endinterface

interface mmst_out_if ();
  import mmst_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OUT_POS_W-1:0]    out_row;
  logic [OUT_POS_W-1:0]    out_col;
  logic signed [VAL_W-1:0] out_value;
  logic                    is_header;
  logic                    last;

  modport source(output valid, out_row, out_col, out_value, is_header, last, input ready);
  modport sink(input valid, out_row, out_col, out_value, is_header, last, output ready);
endinterface

>>> rtl/matrix_multiply_to_sparse_triplets.sv
// Top level: dense A*B product over small matrices, listed as header plus nonzero triplets.
// Depends on mmst_pkg, mmst_if (channels) and mmst_mac (shared MAC unit).
//
//   channel   dir  handshake     payload
//   in_ch     in   valid/ready   req_type, elem_row, elem_col, elem_value
//   out_ch    out  valid/ready   out_row, out_col, out_value, is_header, last
//   cfg_*     in   cfg_we        cfg_index, cfg_data (rows_a, inner_dim, cols_b)
//
// A compute runs through the single MAC (read, multiply, accumulate per term, one write
// per entry), then the header, then a scan and a check per scanned product entry plus an
// emit per nonzero entry. in_ch.ready is high only when no compute is in flight. Output
// words stall freely on out_ch.ready.
// Reset is synchronous on rst_n; stores of A, B and C are not cleared.
module matrix_multiply_to_sparse_triplets
  import mmst_pkg::*;
#(
  parameter int MAX_DIM    = 4,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  mmst_in_if.sink              in_ch,
  mmst_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int MEM_D  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (MEM_D > 1) ? $clog2(MEM_D) : 1;
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CNT_W  = $clog2(MEM_D + 1);

  function automatic logic [DIM_W-1:0] sat_dim(input logic [CFG_W-1:0] v);
    return (int'(v) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(v);
  endfunction

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] rows_a_r, inner_dim_r, cols_b_r;

  logic signed [ELEM_WIDTH-1:0] store_a [MEM_D];
  logic signed [ELEM_WIDTH-1:0] store_b [MEM_D];
  logic [VAL_W-1:0]             store_p [MEM_D];
  logic signed [ELEM_WIDTH-1:0] a_q_r, b_q_r;
  logic [VAL_W-1:0]             p_q_r;

  logic [DIM_W-1:0] nr_r, nr_nxt, nk_r, nk_nxt, nc_r, nc_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, emit_n_r, emit_n_nxt;

  logic [OUT_POS_W-1:0] o_row_r, o_row_nxt, o_col_r, o_col_nxt;
  logic [VAL_W-1:0]     o_val_r, o_val_nxt;
  logic                 o_hdr_r, o_hdr_nxt, o_last_r, o_last_nxt;

  logic [DIM_W-1:0] nr_s, nk_s, nc_s;
  logic             in_fire, out_fire, is_cmp, is_load, ld_ok;
  logic             i_last, j_last, k_last, acc_nz, p_nz;
  logic [IDX_W-1:0] i_adv, j_adv;
  logic [ADDR_W-1:0] ld_addr, a_addr, b_addr, p_addr;
  logic             p_we;
  logic [VAL_W-1:0] acc;
  mac_ctrl_t        mac_ctrl;

  assign nr_s     = sat_dim(rows_a_r);
  assign nk_s     = sat_dim(inner_dim_r);
  assign nc_s     = sat_dim(cols_b_r);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign is_cmp   = req_t'(in_ch.req_type) == REQ_COMPUTE;
  assign is_load  = (req_t'(in_ch.req_type) == REQ_LOAD_A) ||
                    (req_t'(in_ch.req_type) == REQ_LOAD_B);
  assign ld_ok    = (int'(in_ch.elem_row) < MAX_DIM) && (int'(in_ch.elem_col) < MAX_DIM);
  assign ld_addr  = ADDR_W'(int'(in_ch.elem_row) * MAX_DIM + int'(in_ch.elem_col));
  assign a_addr   = ADDR_W'(int'(i_r) * MAX_DIM + int'(k_r));
  assign b_addr   = ADDR_W'(int'(k_r) * MAX_DIM + int'(j_r));
  assign p_addr   = ADDR_W'(int'(i_r) * MAX_DIM + int'(j_r));

  assign i_last = int'(i_r) == int'(nr_r) - 1;
  assign j_last = int'(j_r) == int'(nc_r) - 1;
  assign k_last = int'(k_r) == int'(nk_r) - 1;
  assign acc_nz = acc != '0;
  assign p_nz   = p_q_r != '0;
  assign j_adv  = j_last ? '0 : j_r + 1'b1;
  assign i_adv  = j_last ? (i_last ? '0 : i_r + 1'b1) : i_r;

  mmst_mac #(.ELEM_WIDTH(ELEM_WIDTH)) u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (a_q_r),
    .op_b (b_q_r),
    .acc  (acc)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && is_cmp) begin
          if (nr_s == '0 || nc_s == '0) begin
            state_nxt = ST_HDR;
          end else if (nk_s == '0) begin
            state_nxt = ST_WR;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD:  state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: state_nxt = k_last ? ST_WR : ST_RD;
      ST_WR: begin
        if (i_last && j_last) begin
          state_nxt = ST_HDR;
        end else if (nk_r == '0) begin
          state_nxt = ST_WR;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_HDR: begin
        if (out_fire) begin
          state_nxt = (cnt_r == '0) ? ST_IDLE : ST_SCAN;
        end
      end
      ST_SCAN: state_nxt = ST_CHK;
      ST_CHK:  state_nxt = p_nz ? ST_EMIT : ST_SCAN;
      ST_EMIT: begin
        if (out_fire) begin
          state_nxt = o_last_r ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and strobes
  always_comb begin
    in_ch.ready    = 1'b0;
    out_ch.valid   = 1'b0;
    p_we           = 1'b0;
    mac_ctrl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready    = 1'b1;
        mac_ctrl.clear = in_ch.valid && is_cmp;
      end
      ST_MUL:  mac_ctrl.mul = 1'b1;
      ST_ACC:  mac_ctrl.acc = 1'b1;
      ST_WR: begin
        p_we           = 1'b1;
        mac_ctrl.clear = 1'b1;
      end
      ST_HDR:  out_ch.valid = 1'b1;
      ST_EMIT: out_ch.valid = 1'b1;
      default: ;
    endcase
  end

  // counters and output word
  always_comb begin
    nr_nxt     = nr_r;
    nk_nxt     = nk_r;
    nc_nxt     = nc_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    cnt_nxt    = cnt_r;
    emit_n_nxt = emit_n_r;
    o_row_nxt  = o_row_r;
    o_col_nxt  = o_col_r;
    o_val_nxt  = o_val_r;
    o_hdr_nxt  = o_hdr_r;
    o_last_nxt = o_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && is_cmp) begin
          nr_nxt     = nr_s;
          nk_nxt     = nk_s;
          nc_nxt     = nc_s;
          i_nxt      = '0;
          j_nxt      = '0;
          k_nxt      = '0;
          cnt_nxt    = '0;
          o_row_nxt  = OUT_POS_W'(nr_s);
          o_col_nxt  = OUT_POS_W'(nc_s);
          o_val_nxt  = '0;
          o_hdr_nxt  = 1'b1;
          o_last_nxt = 1'b1;
        end
      end
      ST_ACC: begin
        if (!k_last) begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_WR: begin
        cnt_nxt    = cnt_r + CNT_W'(acc_nz);
        k_nxt      = '0;
        i_nxt      = i_adv;
        j_nxt      = j_adv;
        o_val_nxt  = VAL_W'(cnt_nxt);
        o_last_nxt = cnt_nxt == '0;
      end
      ST_HDR: begin
        if (out_fire) begin
          i_nxt      = '0;
          j_nxt      = '0;
          emit_n_nxt = '0;
        end
      end
      ST_CHK: begin
        if (p_nz) begin
          o_row_nxt  = OUT_POS_W'(i_r);
          o_col_nxt  = OUT_POS_W'(j_r);
          o_val_nxt  = p_q_r;
          o_hdr_nxt  = 1'b0;
          o_last_nxt = (emit_n_r + 1'b1) == cnt_r;
          emit_n_nxt = emit_n_r + 1'b1;
        end else begin
          i_nxt = i_adv;
          j_nxt = j_adv;
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          i_nxt = i_adv;
          j_nxt = j_adv;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rows_a_r    <= DIM_RESET;
      inner_dim_r <= DIM_RESET;
      cols_b_r    <= DIM_RESET;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_ROWS_A:    rows_a_r    <= cfg_data;
          CFG_INNER_DIM: inner_dim_r <= cfg_data;
          CFG_COLS_B:    cols_b_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    nr_r     <= nr_nxt;
    nk_r     <= nk_nxt;
    nc_r     <= nc_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    emit_n_r <= emit_n_nxt;
    o_row_r  <= o_row_nxt;
    o_col_r  <= o_col_nxt;
    o_val_r  <= o_val_nxt;
    o_hdr_r  <= o_hdr_nxt;
    o_last_r <= o_last_nxt;
  end

  // element and product stores
  always_ff @(posedge clk) begin
    if (in_fire && is_load && ld_ok) begin
      if (req_t'(in_ch.req_type) == REQ_LOAD_A) begin
        store_a[ld_addr] <= in_ch.elem_value;
      end else begin
        store_b[ld_addr] <= in_ch.elem_value;
      end
    end
    if (p_we) begin
      store_p[p_addr] <= acc;
    end
    a_q_r <= store_a[a_addr];
    b_q_r <= store_b[b_addr];
    p_q_r <= store_p[p_addr];
  end

  assign out_ch.out_row   = o_row_r;
  assign out_ch.out_col   = o_col_r;
  assign out_ch.out_value = o_val_r;
  assign out_ch.is_header = o_hdr_r;
  assign out_ch.last      = o_last_r;

endmodule

>>> rtl/mmst_mac.sv
// Shared multiply-accumulate unit: registered product, then a 34-bit wrapping accumulator.
// Depends on mmst_pkg.
module mmst_mac
  import mmst_pkg::*;
#(
  parameter int ELEM_WIDTH = 16
) (
  input  logic                         clk,
  input  mac_ctrl_t                    ctrl,
  input  logic signed [ELEM_WIDTH-1:0] op_a,
  input  logic signed [ELEM_WIDTH-1:0] op_b,
  output logic [VAL_W-1:0]             acc
);

  localparam int PROD_W = 2 * ELEM_WIDTH;
  localparam int EXT_W  = (PROD_W > VAL_W) ? PROD_W : VAL_W;

  logic signed [PROD_W-1:0] mult_r;
  logic signed [EXT_W-1:0]  prod_ext;
  logic [VAL_W-1:0]         acc_r;
  logic [VAL_W-1:0]         acc_nxt;

  assign prod_ext = mult_r;

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (ctrl.acc) begin
      acc_nxt = acc_r + prod_ext[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      mult_r <= op_a * op_b;
    end
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

>>> rtl/mmst_checker.sv
// Port-level checks for the matrix multiply block, attached to the top level by bind.
// Depends on mmst_pkg and the top level's channel ports.
module mmst_checker
  import mmst_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [VAL_W-1:0]        out_value,
  input logic                    out_is_header,
  input logic                    out_last
);

  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while an output word is pending");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
    else $error("stalled output word changed");

  a_empty_header_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_header |-> (out_last == (out_value == '0)))
    else $error("header last flag does not match nonzero count");

  a_triplet_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_header |-> out_value != '0)
    else $error("zero entry emitted as triplet");

  a_single_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> !(out_valid && out_is_header))
    else $error("header repeated inside a listing");

endmodule

bind matrix_multiply_to_sparse_triplets mmst_checker u_mmst_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_value     (out_ch.out_value),
  .out_is_header (out_ch.is_header),
  .out_last      (out_ch.last)
);
